FILE: hw/rtl/btop_pkg.sv
// shared constants, types and fixed-point helpers for the binomial tree pricer
// no dependencies
package btop_pkg;

  localparam int MaxSteps = 256;
  localparam int NodeW    = $clog2(MaxSteps + 1);
  localparam int StepW    = 9;
  localparam logic [31:0] Q30One  = 32'h4000_0000;
  localparam logic [63:0] Q30Half = 64'h0000_0000_2000_0000;

  localparam logic [1:0] RegSpot   = 2'd0;
  localparam logic [1:0] RegStrike = 2'd1;
  localparam logic [1:0] RegIsPut  = 2'd2;

  // one command from the sequencer to the cell row
  typedef struct packed {
    logic load;   // load a leaf payoff into the tail cell and shift the row
    logic roll;   // one rollback level: each cell mixes with its neighbor
  } row_ctl_t;

  // round half up at bit 30 and clamp to 32 bits
  function automatic logic [32:0] q30_round(input logic [63:0] prod);
    logic [63:0] s;
    begin
      s = (prod + Q30Half) >> 30;
      q30_round = (s[63:32] != '0) ? {1'b1, 32'hFFFF_FFFF} : {1'b0, s[31:0]};
    end
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] price, input logic [31:0] strike,
                                         input logic put);
    begin
      if (put) payoff = (strike > price) ? strike - price : 32'd0;
      else     payoff = (price > strike) ? price - strike : 32'd0;
    end
  endfunction

endpackage

FILE: hw/rtl/binomial_tree_option_pricer.sv
// top level: config registers, request sequencer, multiplier and cell row
// depends on btop_pkg, btop_mac, btop_cell
//
// usage: write spot, strike and is_put over the cfg port while idle, then
// send one request on in_ (steps, up, down, prob, discount). the block
// generates leaves serially on one multiplier: n products for the lowest
// leaf, then 2n more while leaf payoffs are shifted into a row of
// MaxSteps+1 cells from the tail end, then 256-n alignment shifts.
// rollback runs n levels, each level one pass in which every live cell
// mixes and discounts in parallel, plus one closing pass.
// a new request is taken only once the block is back in idle, after the
// result of the last one is registered.
// the result sits in an output register; a new request may be taken and
// worked on while it waits, but the block holds in its output step until
// the receiver takes the old result, so a stalled receiver stalls the input.
// reset clears control and config; cell contents need no reset.
module binomial_tree_option_pricer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // steps[8:0], up_factor[40:9], down_factor[71:41], prob_up[102:72],
  // step_discount[133:103], zero pad to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // option_value[31:0], saturated[32], zero pad to 40
  output logic [39:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int Cells = btop_pkg::MaxSteps + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DOWN = 6'b000010, S_UP = 6'b000100,
    S_ROLL = 6'b001000, S_SHIFT = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] spot_r, strike_r;
  logic        put_r;
  logic [31:0] up_r, down_r, prob_r, qprob_r, disc_r, leaf_r;
  logic [btop_pkg::StepW-1:0] n_r, cnt_r, sh_r;
  logic        ph_r, upph_r, sat_r;
  logic [31:0] res_r;
  logic        res_sat_r, ovalid_r;

  logic [31:0] mq;
  logic        movf;
  logic [31:0] mac_b;
  btop_pkg::row_ctl_t ctl;
  logic [31:0] cval [Cells];
  logic [Cells-1:0] covf;
  logic [Cells-1:0] clive;
  logic [btop_pkg::StepW-1:0] span;
  logic [31:0] tail_in;

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      btop_pkg::RegSpot:   cfg_prdata = spot_r;
      btop_pkg::RegStrike: cfg_prdata = strike_r;
      btop_pkg::RegIsPut:  cfg_prdata = {31'd0, put_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r <= 32'd6553600; strike_r <= 32'd6553600; put_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        btop_pkg::RegSpot:   spot_r <= cfg_pwdata;
        btop_pkg::RegStrike: strike_r <= cfg_pwdata;
        btop_pkg::RegIsPut:  put_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  wire take = in_tvalid & in_tready;

  assign mac_b = (state_r == S_DOWN) ? down_r : up_r;
  btop_mac u_mac (.clk(clk), .a(leaf_r), .b(mac_b), .q(mq), .ovf(movf));

  // shift command feeds payoff into tail; roll runs on phase 1 of the first n passes
  assign ctl.load = (state_r == S_SHIFT);
  assign ctl.roll = (state_r == S_ROLL) & ph_r & (cnt_r != n_r);
  assign tail_in  = btop_pkg::payoff(leaf_r, strike_r, put_r);

  // cells at or above n - level hold no tree node; their overflow is ignored
  assign span = n_r - cnt_r;

  genvar g;
  generate
    for (g = 0; g < Cells; g++) begin : g_row
      btop_cell u_cell (
        .clk(clk), .ctl(ctl),
        .right_val((g == Cells-1) ? tail_in : cval[(g == Cells-1) ? g : g+1]),
        .prob(prob_r), .qprob(qprob_r), .disc(disc_r),
        .val(cval[g]), .ovf(covf[g])
      );
      assign clive[g] = covf[g] & (9'(g) < span);
    end
  endgenerate

  // rollback of n levels on a row whose leaves sit at the top n+1 cells:
  // values are shifted left by (Cells-1-n) cells before rolling, which puts
  // the lowest leaf in cell 0 and the top leaf in cell n; the root ends in cell 0
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (take) state_nxt = S_DOWN;
      S_DOWN:  if (cnt_r == n_r) state_nxt = S_SHIFT;
      S_UP:    if (ph_r && upph_r) state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = (cnt_r == 0) ? ((sh_r == 0) ? S_ROLL : S_SHIFT) : S_UP;
      S_ROLL:  if (ph_r && cnt_r == n_r) state_nxt = S_OUT;
      S_OUT:   if (!ovalid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [8:0] n_in;
  logic [30:0] p_in;
  assign n_in = (in_tdata[8:0] > 9'(btop_pkg::MaxSteps)) ? 9'(btop_pkg::MaxSteps)
                                                        : in_tdata[8:0];
  assign p_in = (in_tdata[102:72] > btop_pkg::Q30One[30:0]) ? btop_pkg::Q30One[30:0]
                                                             : in_tdata[102:72];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= 1'b0; upph_r <= 1'b0; ovalid_r <= 1'b0;
      cnt_r <= '0; sh_r <= '0; sat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (take) begin
          n_r <= n_in; up_r <= in_tdata[40:9]; down_r <= {1'b0, in_tdata[71:41]};
          prob_r <= {1'b0, p_in}; qprob_r <= btop_pkg::Q30One - {1'b0, p_in};
          disc_r <= {1'b0, in_tdata[133:103]}; leaf_r <= spot_r;
          cnt_r <= '0; ph_r <= 1'b0; sat_r <= 1'b0;
          sh_r <= 9'(Cells - 1) - n_in;
        end
        S_DOWN: begin
          if (cnt_r != n_r) begin
            ph_r <= ~ph_r;
            if (ph_r) begin
              leaf_r <= mq; sat_r <= sat_r | movf; cnt_r <= cnt_r + 1'b1;
            end
          end else ph_r <= 1'b0;
        end
        S_SHIFT: begin
          if (cnt_r == 0) begin
            if (sh_r != 0) sh_r <= sh_r - 1'b1;
            leaf_r <= 32'd0;
          end else cnt_r <= cnt_r - 1'b1;
          ph_r <= 1'b0; upph_r <= 1'b0;
        end
        S_UP: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            leaf_r <= mq; sat_r <= sat_r | movf; upph_r <= ~upph_r;
          end
        end
        S_ROLL: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            cnt_r <= cnt_r + 1'b1;
            sat_r <= sat_r | (|clive);
          end
        end
        S_OUT: if (!ovalid_r) begin
          res_r <= cval[0];
          res_sat_r <= sat_r; ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, res_sat_r, res_r};

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped while stalled");
  a_nmax: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (n_r <= 9'(btop_pkg::MaxSteps))) else $error("steps range");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == S_DOWN)) else $error("no start");
`endif
endmodule

FILE: hw/rtl/btop_mac.sv
// shared multiplier for leaf generation: registered product, then rounding
// depends on btop_pkg
module btop_mac (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] q,
  output logic        ovf
);
  logic [63:0] prod_r;
  logic [32:0] rnd;

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, a} * {32'd0, b};
  end

  assign rnd = btop_pkg::q30_round(prod_r);
  assign q   = rnd[31:0];
  assign ovf = rnd[32];
endmodule

FILE: hw/rtl/btop_cell.sv
// one node of the value row: holds v[k], mixes with its right neighbor
// depends on btop_pkg
module btop_cell (
  input  logic                 clk,
  input  btop_pkg::row_ctl_t   ctl,
  input  logic [31:0]          right_val,
  input  logic [31:0]          prob,
  input  logic [31:0]          qprob,
  input  logic [31:0]          disc,
  output logic [31:0]          val,
  output logic                 ovf
);
  logic [31:0] val_r, val_nxt;
  logic [63:0] mix_r;
  logic [32:0] mrnd;
  logic [32:0] drnd;
  logic [63:0] mixv;

  // first stage: exact mix, registered; second stage: round and discount
  // row holds leaves lowest first, so the right neighbor is the up node
  always_ff @(posedge clk) begin
    mix_r <= {32'd0, qprob} * {32'd0, val_r} + {32'd0, prob} * {32'd0, right_val};
    val_r <= val_nxt;
  end

  assign mrnd = btop_pkg::q30_round(mix_r);
  assign mixv = {32'd0, mrnd[31:0]} * {32'd0, disc};
  assign drnd = btop_pkg::q30_round(mixv);

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) val_nxt = right_val;
    else if (ctl.roll) val_nxt = drnd[31:0];
  end

  assign val = val_r;
  assign ovf = ctl.roll & drnd[32];
endmodule

FILE: dv/binomial_tree_option_pricer_chk.sv
// checker for the binomial tree pricer: tracks config writes, prices each accepted request
// and compares the result stream in order; depends on btop_pkg only for register indexes
module binomial_tree_option_pricer_chk (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           err_count,
  output int           open_prices
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] Q30Unit = 32'h4000_0000;

  logic [31:0] spot_q, strike_q;
  logic        put_q;
  logic [32:0] price_fifo[$];

  // {clamped, value}: q16.16 times q2.30, rounded half up
  function automatic logic [32:0] scale_q30(input logic [31:0] v, input logic [31:0] f);
    logic [63:0] p;
    begin
      p = ({32'd0, v} * {32'd0, f} + 64'h2000_0000) >> 30;
      scale_q30 = (p[63:32] != 0) ? {1'b1, 32'hFFFF_FFFF} : {1'b0, p[31:0]};
    end
  endfunction

  function automatic logic [31:0] claim(input logic [31:0] px, input logic [31:0] k,
                                        input logic put);
    begin
      if (put) claim = (k > px) ? k - px : 32'd0;
      else     claim = (px > k) ? px - k : 32'd0;
    end
  endfunction

  // {saturated, root value} of one tree
  function automatic logic [32:0] price_tree(input logic [8:0] steps, input logic [31:0] up,
                                             input logic [30:0] dn, input logic [30:0] pu,
                                             input logic [30:0] disc, input logic [31:0] s,
                                             input logic [31:0] k, input logic put);
    logic [31:0] vals[0:256];
    logic [31:0] px, p, q;
    logic [32:0] r;
    logic [63:0] mix;
    logic        sat;
    int          n;
    begin
      sat = 1'b0;
      n = (steps > 256) ? 256 : steps;
      p = ({1'b0, pu} > Q30Unit) ? Q30Unit : {1'b0, pu};
      q = Q30Unit - p;
      px = s;
      for (int i = 0; i < n; i++) begin
        r = scale_q30(px, {1'b0, dn}); px = r[31:0]; sat |= r[32];
      end
      vals[n] = claim(px, k, put);
      for (int i = n; i > 0; i--) begin
        r = scale_q30(px, up); px = r[31:0]; sat |= r[32];
        r = scale_q30(px, up); px = r[31:0]; sat |= r[32];
        vals[i-1] = claim(px, k, put);
      end
      for (int j = 0; j < n; j++) begin
        for (int m = 0; m < n - j; m++) begin
          mix = {32'd0, p} * {32'd0, vals[m]} + {32'd0, q} * {32'd0, vals[m+1]}
              + 64'h2000_0000;
          r = scale_q30(mix[61:30], {1'b0, disc});
          vals[m] = r[31:0]; sat |= r[32];
        end
      end
      price_tree = {sat, vals[0]};
    end
  endfunction

  assign open_prices = price_fifo.size();

  always @(posedge clk) begin
    logic [32:0] want;
    if (!rst_n) begin
      spot_q <= 32'd6553600;
      strike_q <= 32'd6553600;
      put_q <= 1'b0;
      err_count <= 0;
      price_fifo.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          btop_pkg::RegSpot:   spot_q <= cfg_pwdata;
          btop_pkg::RegStrike: strike_q <= cfg_pwdata;
          btop_pkg::RegIsPut:  put_q <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        price_fifo.push_back(price_tree(in_tdata[8:0], in_tdata[40:9], in_tdata[71:41],
                                        in_tdata[102:72], in_tdata[133:103],
                                        spot_q, strike_q, put_q));
      if (out_tvalid && out_tready) begin
        if (price_fifo.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          err_count <= err_count + 1;
        end else begin
          want = price_fifo.pop_front();
          if (out_tdata[31:0] !== want[31:0] || out_tdata[32] !== want[32]) begin
            $display("%0t: mismatch value exp %h got %h, saturated exp %b got %b", $time,
                     want[31:0], out_tdata[31:0], want[32], out_tdata[32]);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/binomial_tree_option_pricer_tb.sv
// testbench top for the binomial tree pricer: clock, reset, config writes and request stimulus
// depends on btop_pkg, binomial_tree_option_pricer and binomial_tree_option_pricer_chk
module binomial_tree_option_pricer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // steps, up_factor, down_factor, prob_up, step_discount from bit 0, zero pad
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // option_value, saturated from bit 0, zero pad
  logic [39:0]  out_tdata;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           err_count, open_prices;

  // idle odds in percent, and long receiver hold-off requests
  int tx_idle = 12, rx_idle = 67;
  int hold_asks = 0, hold_seen = 0, hold_left = 0;
  int cyc = 0;

  always #1 clk = ~clk;

  binomial_tree_option_pricer uut (.*);

  binomial_tree_option_pricer_chk chk (.*);

  // watchdog: slowest run is well under this
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= 4000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // setup then access phase; register lands at the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // stop offering, let the last accepted request reach the checker, drain, then write the new contract
  task automatic set_contract(input logic [31:0] s, input logic [31:0] k, input logic put);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_prices != 0) @(posedge clk);
    cfg_write(btop_pkg::RegSpot, s);
    cfg_write(btop_pkg::RegStrike, k);
    cfg_write(btop_pkg::RegIsPut, {31'd0, put});
  endtask

  // offer one request; valid stays up across back-to-back requests
  task automatic send_request(input logic [8:0] n, input logic [31:0] u, input logic [30:0] d,
                              input logic [30:0] p, input logic [30:0] disc);
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, disc, p, d, u, n};
    do @(posedge clk); while (!in_tready);
  endtask

  // realistic tree: u slightly above one, d = 1/u, p near half, discount just below one
  task automatic send_market(input logic [8:0] n);
    logic [31:0] u;
    logic [63:0] d;
    u = 32'h4000_0000 + $urandom_range(0, 32'h0100_0000);
    d = (64'd1 << 60) / u;
    send_request(n, u, d[30:0], 31'($urandom_range(32'h1C00_0000, 32'h2400_0000)),
                 31'(32'h4000_0000 - $urandom_range(0, 32'h0010_0000)));
  endtask

  // mostly short trees, now and then a long or clamped one
  function automatic logic [8:0] pick_steps();
    pick_steps = ($urandom_range(9) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 20));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default contract, zero/one/max/clamped step counts
    send_request(9'd0, 32'h40A3_D70A, 31'h3F5A_2B3C, 31'h2000_0000, 31'h3FF0_0000);
    send_request(9'd1, 32'h40A3_D70A, 31'h3F5A_2B3C, 31'h2000_0000, 31'h3FF0_0000);
    send_request(9'd256, 32'h4010_0000, 31'h3FF0_0FF0, 31'h2000_0000, 31'h3FFF_0000);
    send_request(9'd511, 32'h4010_0000, 31'h3FF0_0FF0, 31'h2000_0000, 31'h3FFF_0000);
    // probability above one clamps, probability zero, discount zero
    send_request(9'd5, 32'h4100_0000, 31'h3F00_0000, 31'h7FFF_FFFF, 31'h4000_0000);
    send_request(9'd5, 32'h4100_0000, 31'h3F00_0000, 31'h0000_0000, 31'h0000_0000);
    // factors and discount above one: overflow clamps and flags; then a zero down factor
    send_request(9'd8, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h4000_0000, 31'h7FFF_FFFF);
    send_request(9'd3, 32'h4000_0000, 31'h0000_0000, 31'h1000_0000, 31'h4000_0000);

    // put, zero spot
    set_contract(32'd0, 32'h0064_0000, 1'b1);
    send_request(9'd4, 32'h4100_0000, 31'h3F00_0000, 31'h2000_0000, 31'h3FF0_0000);
    send_request(9'd0, 32'h4100_0000, 31'h3F00_0000, 31'h2000_0000, 31'h3FF0_0000);
    // put, max spot and strike, clamped leaf prices
    set_contract(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(9'd6, 32'hC000_0000, 31'h2000_0000, 31'h2000_0000, 31'h4000_0000);
    send_request(9'd2, 32'h4000_0000, 31'h4000_0000, 31'h4000_0000, 31'h4000_0000);
    // call, max spot, zero strike
    set_contract(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_request(9'd6, 32'hC000_0000, 31'h2000_0000, 31'h2000_0000, 31'h4000_0000);
    send_request(9'd10, 32'h4080_0000, 31'h3F80_0000, 31'h2000_0000, 31'h3FC0_0000);

    // random: three idling phases, each several contracts
    for (int phase = 0; phase < 3; phase++) begin
      for (int c = 0; c < 4; c++) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        if (phase == 0) begin tx_idle = 12; rx_idle = 67; end
        else if (phase == 1) begin tx_idle = 67; rx_idle = 12; end
        else begin tx_idle = 0; rx_idle = 0; end
        set_contract($urandom_range(32'h0020_0000, 32'h0200_0000),
                     $urandom_range(32'h0020_0000, 32'h0200_0000), 1'($urandom_range(1)));
        if (phase == 2 && c == 0) hold_asks = hold_asks + 1;
        for (int i = 0; i < 7; i++) begin
          if ($urandom_range(4) == 0)
            send_request(pick_steps(), $urandom, 31'($urandom), 31'($urandom),
                         31'($urandom));
          else
            send_market(pick_steps());
        end
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (open_prices != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
